/* sv/fbt_pkg.sv */
// Shared types and constants for the flow bulk tracker.
`default_nettype none

package fbt_pkg;

   // Field widths
   localparam int TIME_BITS  = 48;
   localparam int LEN_W      = 16;
   localparam int CNT_W      = 32;
   localparam int TOT_W      = 48;
   localparam int PKT_W      = 8;
   localparam int GAP_W      = 32;

   // Stream and register port widths
   localparam int REQ_DATA_W = ((LEN_W + TIME_BITS + 7) / 8) * 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 320;
   localparam int RSP_USER_W = 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // Register defaults
   localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(1000000);
   localparam logic [PKT_W-1:0] MIN_RESET = PKT_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BULK_GAP = 1'b0,
      CSR_BULK_MIN = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_ADD      = 1'b0,
      CMD_NEW_FLOW = 1'b1
   } command_type;

   typedef struct packed {
      command_type           command;
      logic                  from_server;
      logic [LEN_W-1:0]      payload_len;
      logic [TIME_BITS-1:0]  arrival_us;
   } packet_type;

   typedef struct packed {
      logic [GAP_W-1:0] bulk_gap_us;
      logic [PKT_W-1:0] bulk_min_packets;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] bulks;
      logic [CNT_W-1:0] packets;
      logic [TOT_W-1:0] bytes;
      logic [TOT_W-1:0] time_us;
   } totals_type;

   typedef struct packed {
      logic                 cand_open;
      logic [TIME_BITS-1:0] cand_start_us;
      logic [TIME_BITS-1:0] bulk_last_us;
      logic [CNT_W-1:0]     cand_bytes;
      logic [PKT_W-1:0]     cand_packets;
      totals_type           totals;
   } dir_state_type;

   typedef struct packed {
      totals_type fwd;
      totals_type bwd;
      logic       in_bulk;
   } result_type;

endpackage

`default_nettype wire

/* sv/fbt_in_reg.sv */
// Input register stage that holds one packet transaction until the core takes it.
`default_nettype none

module fbt_in_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire fbt_pkg::packet_type in_pkt,
   output logic                     out_valid,
   input  wire logic                out_take,
   output fbt_pkg::packet_type      out_pkt
);

   logic                valid_ff;
   logic                valid_in;
   fbt_pkg::packet_type pkt_ff;

   // Accept whenever the slot is empty or drains this cycle
   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = in_valid || (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_pkt   = pkt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ready ? in_valid : valid_in;
      end
   end

   // Load payload on every accepted transaction
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pkt_ff <= in_pkt;
      end
   end

endmodule

`default_nettype wire

/* sv/fbt_core.sv */
// Per-direction bulk state and the single-pass update for one packet.
`default_nettype none

module fbt_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire fbt_pkg::packet_type pkt,
   input  wire fbt_pkg::cfg_type    cfg,
   output fbt_pkg::result_type      result
);

   fbt_pkg::dir_state_type state_ff [2];
   fbt_pkg::dir_state_type state_in [2];

   function automatic logic [fbt_pkg::CNT_W-1:0] sat_cnt(
      input logic [fbt_pkg::CNT_W-1:0] a,
      input logic [fbt_pkg::CNT_W-1:0] b
   );
      logic [fbt_pkg::CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[fbt_pkg::CNT_W] ? '1 : s[fbt_pkg::CNT_W-1:0];
   endfunction

   function automatic logic [fbt_pkg::TOT_W-1:0] sat_tot(
      input logic [fbt_pkg::TOT_W-1:0] a,
      input logic [fbt_pkg::TOT_W-1:0] b
   );
      logic [fbt_pkg::TOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[fbt_pkg::TOT_W] ? '1 : s[fbt_pkg::TOT_W-1:0];
   endfunction

   function automatic logic [fbt_pkg::TIME_BITS-1:0] pos_diff(
      input logic [fbt_pkg::TIME_BITS-1:0] later,
      input logic [fbt_pkg::TIME_BITS-1:0] earlier
   );
      return (later > earlier) ? later - earlier : '0;
   endfunction

   // Compute the next state of both directions and the result
   always_comb begin
      fbt_pkg::dir_state_type       cur [2];
      fbt_pkg::dir_state_type       cs;
      fbt_pkg::dir_state_type       os;
      fbt_pkg::dir_state_type       ns;
      logic [fbt_pkg::TIME_BITS-1:0] gap_diff;
      logic [fbt_pkg::TIME_BITS-1:0] run_diff;
      logic [fbt_pkg::CNT_W-1:0]     new_bytes;
      logic [fbt_pkg::PKT_W-1:0]     prior_pkts;
      logic [fbt_pkg::PKT_W-1:0]     new_pkts;
      logic                          d;

      d = pkt.from_server;
      for (int k = 0; k < 2; k++) begin
         cur[k] = (pkt.command == fbt_pkg::CMD_NEW_FLOW) ? '0 : state_ff[k];
      end
      cs = cur[d];
      os = cur[!d];
      ns = cs;

      // Drop the candidate once the other side's bulk ran past its start
      if (cs.cand_open && (os.bulk_last_us > cs.cand_start_us)) begin
         ns.cand_open = 1'b0;
      end

      gap_diff   = pos_diff(pkt.arrival_us, cs.bulk_last_us);
      run_diff   = pos_diff(pkt.arrival_us, cs.cand_start_us);
      prior_pkts = cs.cand_packets;
      new_bytes  = sat_cnt(cs.cand_bytes,
                           {{(fbt_pkg::CNT_W-fbt_pkg::LEN_W){1'b0}}, pkt.payload_len});
      new_pkts   = (prior_pkts == '1) ? prior_pkts : prior_pkts + fbt_pkg::PKT_W'(1);

      if (pkt.payload_len != '0) begin
         if (!ns.cand_open ||
             (gap_diff > {{(fbt_pkg::TIME_BITS-fbt_pkg::GAP_W){1'b0}}, cfg.bulk_gap_us})) begin
            // Restart the candidate at this packet
            ns.cand_open     = 1'b1;
            ns.cand_bytes    = {{(fbt_pkg::CNT_W-fbt_pkg::LEN_W){1'b0}}, pkt.payload_len};
            ns.cand_packets  = fbt_pkg::PKT_W'(1);
            ns.cand_start_us = pkt.arrival_us;
            ns.bulk_last_us  = pkt.arrival_us;
         end else begin
            ns.cand_bytes   = new_bytes;
            ns.cand_packets = new_pkts;
            if (prior_pkts >= cfg.bulk_min_packets) begin
               // Extend a running bulk
               ns.totals.packets = sat_cnt(cs.totals.packets, fbt_pkg::CNT_W'(1));
               ns.totals.bytes   = sat_tot(cs.totals.bytes,
                  {{(fbt_pkg::TOT_W-fbt_pkg::LEN_W){1'b0}}, pkt.payload_len});
               ns.totals.time_us = sat_tot(cs.totals.time_us, gap_diff);
            end else if (new_pkts == cfg.bulk_min_packets) begin
               // Promote the candidate to a bulk
               ns.totals.bulks   = sat_cnt(cs.totals.bulks, fbt_pkg::CNT_W'(1));
               ns.totals.packets = sat_cnt(cs.totals.packets,
                  {{(fbt_pkg::CNT_W-fbt_pkg::PKT_W){1'b0}}, new_pkts});
               ns.totals.bytes   = sat_tot(cs.totals.bytes,
                  {{(fbt_pkg::TOT_W-fbt_pkg::CNT_W){1'b0}}, new_bytes});
               ns.totals.time_us = sat_tot(cs.totals.time_us, run_diff);
            end
            ns.bulk_last_us = pkt.arrival_us;
         end
      end

      state_in[d]  = ns;
      state_in[!d] = os;

      result.fwd     = state_in[0].totals;
      result.bwd     = state_in[1].totals;
      result.in_bulk = ns.cand_open && (ns.cand_packets >= cfg.bulk_min_packets);
   end

   // Commit the update when the packet moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff[0] <= '0;
         state_ff[1] <= '0;
      end else if (advance) begin
         state_ff[0] <= state_in[0];
         state_ff[1] <= state_in[1];
      end
   end

endmodule

`default_nettype wire

/* sv/flow_bulk_tracker.sv */
// Path: an accepted packet waits in the input register, then moves with its
//   result into the result register, from which it can be taken.
// Throughput: one packet transaction per cycle when rsp_tready does not stall;
//   the input register takes a new packet while a finished result waits in
//   the result register only if it is empty. Reset: clears all per-direction
//   bulk state, restores bulk_gap_us to 1000000 and bulk_min_packets to 4.
`default_nettype none

module flow_bulk_tracker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // payload_len[15:0], arrival_us[63:16]
   input  wire logic [fbt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command[0], from_server[1]
   input  wire logic [fbt_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // fwd_bulks[31:0], fwd_bulk_packets[63:32], fwd_bulk_bytes[111:64],
   // fwd_bulk_time_us[159:112], bwd_bulks[191:160], bwd_bulk_packets[223:192],
   // bwd_bulk_bytes[271:224], bwd_bulk_time_us[319:272]
   output logic [fbt_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // in_bulk[0]
   output logic [fbt_pkg::RSP_USER_W-1:0]        rsp_tuser,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fbt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [fbt_pkg::CSR_DATA_W-1:0]   csr_data
);

   fbt_pkg::packet_type in_pkt;
   fbt_pkg::packet_type core_pkt;
   fbt_pkg::cfg_type    cfg_ff;
   fbt_pkg::result_type core_result;
   fbt_pkg::result_type result_ff;
   logic                core_valid;
   logic                advance;
   logic                rsp_valid_ff;

   // Unpack the request transaction
   assign in_pkt.command     = fbt_pkg::command_type'(req_tuser[0]);
   assign in_pkt.from_server = req_tuser[1];
   assign in_pkt.payload_len = req_tdata[fbt_pkg::LEN_W-1:0];
   assign in_pkt.arrival_us  = req_tdata[fbt_pkg::LEN_W +: fbt_pkg::TIME_BITS];

   // Move a packet on when the result register is free or drains
   assign advance = core_valid && (!rsp_valid_ff || rsp_tready);

   fbt_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pkt    (in_pkt),
      .out_valid (core_valid),
      .out_take  (advance),
      .out_pkt   (core_pkt)
   );

   fbt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .pkt     (core_pkt),
      .cfg     (cfg_ff),
      .result  (core_result)
   );

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bulk_gap_us      <= fbt_pkg::GAP_RESET;
         cfg_ff.bulk_min_packets <= fbt_pkg::MIN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (fbt_pkg::csr_index_type'(csr_index))
            fbt_pkg::CSR_BULK_GAP: cfg_ff.bulk_gap_us      <= csr_data;
            fbt_pkg::CSR_BULK_MIN: cfg_ff.bulk_min_packets <= csr_data[fbt_pkg::PKT_W-1:0];
            default: ;
         endcase
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {result_ff.bwd.time_us, result_ff.bwd.bytes,
                        result_ff.bwd.packets, result_ff.bwd.bulks,
                        result_ff.fwd.time_us, result_ff.fwd.bytes,
                        result_ff.fwd.packets, result_ff.fwd.bulks};
   assign rsp_tuser  = result_ff.in_bulk;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the flow bulk tracker: directed and random packet streams.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
   localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;
   localparam logic [63:0] MAX8  = 64'hFF;
   localparam logic [63:0] ONE   = 64'd1;

   // Bulk predictor and queue of expected per-packet totals
   class bulk_scoreboard;
      logic [fbt_pkg::GAP_W-1:0]     gap_us;
      logic [fbt_pkg::PKT_W-1:0]     min_pkts;
      logic                          cand_open [2];
      logic [fbt_pkg::TIME_BITS-1:0] cand_start [2];
      logic [fbt_pkg::TIME_BITS-1:0] last_us [2];
      logic [fbt_pkg::CNT_W-1:0]     cand_bytes [2];
      logic [fbt_pkg::PKT_W-1:0]     cand_pkts [2];
      fbt_pkg::totals_type           tot [2];
      fbt_pkg::result_type           expected_totals [$];
      int                            fails;

      function new();
         fails    = 0;
         gap_us   = fbt_pkg::GAP_RESET;
         min_pkts = fbt_pkg::MIN_RESET;
         clear_flow();
      endfunction

      function void clear_flow();
         for (int d = 0; d < 2; d++) begin
            cand_open[d]  = 1'b0;
            cand_start[d] = '0;
            last_us[d]    = '0;
            cand_bytes[d] = '0;
            cand_pkts[d]  = '0;
            tot[d]        = '0;
         end
      endfunction

      function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] max);
         if (a >= max || b >= max - a) return max;
         return a + b;
      endfunction

      function logic [63:0] pos_diff(logic [63:0] later, logic [63:0] earlier);
         return (later > earlier) ? later - earlier : 64'd0;
      endfunction

      function void write_reg(fbt_pkg::csr_index_type idx,
                              logic [fbt_pkg::CSR_DATA_W-1:0] value);
         if (idx == fbt_pkg::CSR_BULK_GAP) gap_us = value;
         else if (idx == fbt_pkg::CSR_BULK_MIN) min_pkts = value[fbt_pkg::PKT_W-1:0];
      endfunction

      // Advance the per-direction state by one packet and queue the totals it yields
      function void note_packet(fbt_pkg::packet_type pkt);
         int                  d;
         int                  o;
         logic [63:0]         prior;
         logic [63:0]         t;
         logic [63:0]         len;
         fbt_pkg::result_type r;
         d   = pkt.from_server ? 1 : 0;
         o   = 1 - d;
         t   = 64'(pkt.arrival_us);
         len = 64'(pkt.payload_len);
         if (pkt.command == fbt_pkg::CMD_NEW_FLOW) clear_flow();
         // drop a candidate that the other side's bulk has overtaken
         if (cand_open[d] && last_us[o] > cand_start[d]) cand_open[d] = 1'b0;
         if (pkt.payload_len != 0) begin
            if (!cand_open[d] || pos_diff(t, 64'(last_us[d])) > {32'd0, gap_us}) begin
               cand_open[d]  = 1'b1;
               cand_bytes[d] = fbt_pkg::CNT_W'(pkt.payload_len);
               cand_pkts[d]  = fbt_pkg::PKT_W'(1);
               cand_start[d] = pkt.arrival_us;
               last_us[d]    = pkt.arrival_us;
            end else begin
               prior         = 64'(cand_pkts[d]);
               cand_bytes[d] = fbt_pkg::CNT_W'(sat_add(64'(cand_bytes[d]), len, MAX32));
               cand_pkts[d]  = fbt_pkg::PKT_W'(sat_add(prior, ONE, MAX8));
               if (prior >= 64'(min_pkts)) begin
                  tot[d].packets = fbt_pkg::CNT_W'(sat_add(64'(tot[d].packets), ONE, MAX32));
                  tot[d].bytes   = fbt_pkg::TOT_W'(sat_add(64'(tot[d].bytes), len, MAX48));
                  tot[d].time_us = fbt_pkg::TOT_W'(sat_add(64'(tot[d].time_us),
                                      pos_diff(t, 64'(last_us[d])), MAX48));
               end else if (cand_pkts[d] == min_pkts) begin
                  tot[d].bulks   = fbt_pkg::CNT_W'(sat_add(64'(tot[d].bulks), ONE, MAX32));
                  tot[d].packets = fbt_pkg::CNT_W'(sat_add(64'(tot[d].packets),
                                      64'(cand_pkts[d]), MAX32));
                  tot[d].bytes   = fbt_pkg::TOT_W'(sat_add(64'(tot[d].bytes),
                                      64'(cand_bytes[d]), MAX48));
                  tot[d].time_us = fbt_pkg::TOT_W'(sat_add(64'(tot[d].time_us),
                                      pos_diff(t, 64'(cand_start[d])), MAX48));
               end
               last_us[d] = pkt.arrival_us;
            end
         end
         r.fwd     = tot[0];
         r.bwd     = tot[1];
         r.in_bulk = cand_open[d] && (cand_pkts[d] >= min_pkts);
         expected_totals = {expected_totals, r};
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fails++;
         end
      endfunction

      function void check_result(logic [fbt_pkg::RSP_DATA_W-1:0] data, logic in_bulk);
         fbt_pkg::result_type want;
         fbt_pkg::totals_type side_tot;
         string               side;
         int                  base;
         if (expected_totals.size() == 0) begin
            $display("%0t: result transaction with nothing expected, tdata %0h", $time, data);
            fails++;
            return;
         end
         want = expected_totals.pop_front();
         for (int k = 0; k < 2; k++) begin
            side_tot = (k == 0) ? want.fwd : want.bwd;
            side     = (k == 0) ? "fwd" : "bwd";
            base     = k * 160;
            compare_field({side, "_bulks"}, 64'(side_tot.bulks), 64'(data[base +: 32]));
            compare_field({side, "_bulk_packets"}, 64'(side_tot.packets),
                          64'(data[base + 32 +: 32]));
            compare_field({side, "_bulk_bytes"}, 64'(side_tot.bytes),
                          64'(data[base + 64 +: 48]));
            compare_field({side, "_bulk_time_us"}, 64'(side_tot.time_us),
                          64'(data[base + 112 +: 48]));
         end
         compare_field("in_bulk", 64'(want.in_bulk), 64'(in_bulk));
      endfunction

      function int pending();
         return expected_totals.size();
      endfunction
   endclass

   logic                                clock      = 1'b0;
   logic                                reset      = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   // payload_len[15:0], arrival_us[63:16]
   logic [fbt_pkg::REQ_DATA_W-1:0]      req_tdata  = '0;
   // command[0], from_server[1]
   logic [fbt_pkg::REQ_USER_W-1:0]      req_tuser  = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // fwd totals in [159:0], bwd totals in [319:160]
   logic [fbt_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   // in_bulk[0]
   logic [fbt_pkg::RSP_USER_W-1:0]      rsp_tuser;
   logic                                csr_valid  = 1'b0;
   logic                                csr_ready;
   logic [fbt_pkg::CSR_IDX_W-1:0]       csr_index  = '0;
   logic [fbt_pkg::CSR_DATA_W-1:0]      csr_data   = '0;

   bulk_scoreboard sb;
   logic [fbt_pkg::GAP_W-1:0] gap_setting = fbt_pkg::GAP_RESET;
   logic                      calm        = 1'b0;
   int                        ready_hold  = 0;
   int                        idle_cycles = 0;

   flow_bulk_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(30, 120));
   endfunction

   function automatic logic [fbt_pkg::TIME_BITS-1:0] rand_time();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[fbt_pkg::TIME_BITS-1:0];
   endfunction

   // Throttle the result side
   always @(posedge clock) begin
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
         ready_hold <= pick_gap();
      end
   end

   // Observe every transaction on the three channels
   always @(posedge clock) begin
      fbt_pkg::packet_type pkt;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pkt.command     = fbt_pkg::command_type'(req_tuser[0]);
            pkt.from_server = req_tuser[1];
            pkt.payload_len = req_tdata[fbt_pkg::LEN_W-1:0];
            pkt.arrival_us  = req_tdata[fbt_pkg::LEN_W +: fbt_pkg::TIME_BITS];
            sb.note_packet(pkt);
         end
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser[0]);
         if (csr_valid && csr_ready) begin
            sb.write_reg(fbt_pkg::csr_index_type'(csr_index), csr_data);
         end
      end
   end

   // End the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_packet(fbt_pkg::command_type cmd, logic dir,
                              logic [fbt_pkg::LEN_W-1:0] len,
                              logic [fbt_pkg::TIME_BITS-1:0] t);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {t, len};
      req_tuser  <= {dir, cmd};
      do @(posedge clock); while (!req_tready);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lower valid and hold until every queued result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(fbt_pkg::csr_index_type idx,
                            logic [fbt_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Upper data bits of the minimum register carry junk
   task automatic set_config(logic [fbt_pkg::GAP_W-1:0] gap,
                             logic [fbt_pkg::PKT_W-1:0] min_pkts);
      logic [31:0] junk;
      junk = $urandom;
      write_csr(fbt_pkg::CSR_BULK_GAP, gap);
      write_csr(fbt_pkg::CSR_BULK_MIN, {junk[31:8], min_pkts});
      gap_setting = gap;
   endtask

   // Random flows: bursts per direction, timestamps stepped around the gap limit
   task automatic run_random(int count);
      logic [fbt_pkg::TIME_BITS-1:0] now;
      logic [63:0]                   step;
      fbt_pkg::command_type          cmd;
      logic                          dir;
      logic [fbt_pkg::LEN_W-1:0]     len;
      int                            flow_left;
      int                            burst_left;
      int                            r;
      flow_left  = 0;
      burst_left = 0;
      dir        = 1'b0;
      now        = '0;
      for (int i = 0; i < count; i++) begin
         cmd = fbt_pkg::CMD_ADD;
         if (flow_left == 0 || $urandom_range(0, 99) < 3) begin
            cmd       = fbt_pkg::CMD_NEW_FLOW;
            flow_left = int'($urandom_range(5, 40));
            now       = ($urandom_range(0, 9) == 0)
                        ? ({16'hFFFF, 32'h0} | 48'($urandom_range(0, 255)))
                        : rand_time();
         end
         if (burst_left == 0) begin
            dir        = 1'($urandom_range(0, 1));
            burst_left = int'($urandom_range(1, 10));
         end
         r = int'($urandom_range(0, 99));
         if (r < 10) len = '0;
         else if (r < 15) len = '1;
         else if (r < 30) len = fbt_pkg::LEN_W'($urandom_range(1, 64));
         else len = fbt_pkg::LEN_W'($urandom_range(1, 65535));
         r    = int'($urandom_range(0, 99));
         step = 64'd0;
         if (r < 45) step = 64'($urandom_range(0, gap_setting));
         else if (r < 60) step = 64'(gap_setting >> $urandom_range(0, 31));
         else if (r < 70) step = 64'(gap_setting);
         else if (r < 80) step = {32'd0, gap_setting} + 64'd1;
         else if (r < 90) step = {32'd0, gap_setting} + 64'($urandom);
         else if (r < 95) now = now - fbt_pkg::TIME_BITS'($urandom_range(0, 1000));
         else now = rand_time();
         now = now + step[fbt_pkg::TIME_BITS-1:0];
         send_packet(cmd, dir, len, now);
         flow_left--;
         burst_left--;
      end
   endtask

   // One long forward run that drives the candidate counter into saturation
   task automatic run_long(int count);
      logic [fbt_pkg::TIME_BITS-1:0] now;
      now = rand_time() >> 1;
      send_packet(fbt_pkg::CMD_NEW_FLOW, 1'b0,
                  fbt_pkg::LEN_W'($urandom_range(1, 65535)), now);
      for (int i = 1; i < count; i++) begin
         now = now + fbt_pkg::TIME_BITS'($urandom_range(0, 5000));
         if ($urandom_range(0, 39) == 0) begin
            send_packet(fbt_pkg::CMD_ADD, 1'b1, '0, now);
         end else begin
            send_packet(fbt_pkg::CMD_ADD, 1'b0,
                        fbt_pkg::LEN_W'($urandom_range(0, 65535)), now);
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: bulk formation, empty payload, gap edges, drop, time wrap
      set_config(32'd1000, 8'd3);
      send_packet(fbt_pkg::CMD_NEW_FLOW, 1'b0, 16'd100, 48'd1000);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'd200, 48'd1100);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'd300, 48'd1200);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'hFFFF, 48'd1300);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'd0, 48'd1400);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'd10, 48'd2301);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'd20, 48'd3301);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'd30, 48'd3200);
      send_packet(fbt_pkg::CMD_ADD, 1'b1, 16'd50, 48'd3000);
      send_packet(fbt_pkg::CMD_ADD, 1'b1, 16'd60, 48'd3100);
      send_packet(fbt_pkg::CMD_ADD, 1'b1, 16'd70, 48'd3250);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'd5, 48'd3400);
      send_packet(fbt_pkg::CMD_ADD, 1'b1, 16'd0, 48'd3500);
      send_packet(fbt_pkg::CMD_NEW_FLOW, 1'b1, 16'd1, 48'hFFFF_FFFF_FFFF);
      send_packet(fbt_pkg::CMD_ADD, 1'b1, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
      send_packet(fbt_pkg::CMD_ADD, 1'b1, 16'd1, 48'd0);
      send_packet(fbt_pkg::CMD_ADD, 1'b1, 16'd2, 48'd10);
      send_packet(fbt_pkg::CMD_ADD, 1'b0, 16'd0, 48'd0);
      send_packet(fbt_pkg::CMD_NEW_FLOW, 1'b0, 16'd0, 48'd0);
      drain();

      // Default settings, with a full pause halfway
      set_config(fbt_pkg::GAP_RESET, fbt_pkg::MIN_RESET);
      run_random(25);
      drain();
      run_random(25);
      drain();

      set_config(32'd0, 8'd2);
      run_random(25);
      drain();

      set_config(32'hFFFF_FFFF, 8'd255);
      run_long(280);
      drain();

      set_config(32'd50, 8'd1);
      run_random(15);
      drain();

      set_config(32'd20000, 8'd0);
      run_random(15);
      drain();

      // Back-to-back stretch with no idling on either side
      set_config(32'd3000, 8'd2);
      calm = 1'b1;
      run_random(15);
      calm = 1'b0;
      run_random(15);
      drain();

      repeat (8) @(posedge clock);
      if (sb.fails == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
